// ----- src/rdm_pkg.sv -----
// Package: word types, opcodes, status codes and register indexes of the deadlock manager.
`default_nettype none
package rdm_pkg;

    // Input opcodes
    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_REQUEST = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_RESCAN  = 3'd3;
    localparam logic [2:0] OP_DETECT  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_LOADED   = 3'd0;
    localparam logic [2:0] ST_GRANTED  = 3'd1;
    localparam logic [2:0] ST_WAITING  = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_VICTIM   = 3'd4;
    localparam logic [2:0] ST_NO_DL    = 3'd5;
    localparam logic [2:0] ST_NO_WAIT  = 3'd6;

    // Configuration register indexes
    localparam logic CFG_PROCS = 1'b0;
    localparam logic CFG_RSRCS = 1'b1;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] process_index;
        logic [3:0] resource_index;
        logic [5:0] amount;
    } req_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] process_out;
        logic [5:0] available_out;
        logic [8:0] grant_count;
        logic       last;
    } rsp_word_t;

endpackage
`default_nettype wire

// ----- src/rdm_alu.sv -----
// Shared arithmetic unit: wide add/subtract with compare, and a saturating count add.
`default_nettype none
module rdm_alu #(
    parameter int CB = 6,
    parameter int WB = 11
) (
    input  wire logic          sub,
    input  wire logic [WB-1:0] x,
    input  wire logic [WB-1:0] y,
    input  wire logic [CB-1:0] u,
    input  wire logic [CB-1:0] v,
    output logic      [WB-1:0] res,
    output logic               ge,
    output logic      [CB-1:0] sat
);
    logic [WB:0] diff;
    logic [CB:0] sum;

    // x - y with borrow gives the compare
    assign diff = {1'b0, x} - {1'b0, y};
    assign ge   = ~diff[WB];
    assign res  = sub ? diff[WB-1:0] : x + y;

    // count add clamps at all ones
    assign sum = {1'b0, u} + {1'b0, v};
    assign sat = sum[CB] ? {CB{1'b1}} : sum[CB-1:0];
endmodule
`default_nettype wire

// ----- src/resource_deadlock_manager_unit.sv -----
// Top level: resource allocation manager with sequential deadlock detection and recovery.
//
//  channel | signals                              | word
//  --------+--------------------------------------+-----------------------------
//  req     | req_valid, req_ready, req_data       | opcode, indexes, amount
//  rsp     | rsp_valid, rsp_ready, rsp_data       | status, process, count, last
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | active process/resource count
//
// Load and unused opcodes pass through the result read and emit states; request and
// release add a read and a write state; rescan reads and evaluates each active entry.
// Detect copies free counts into work, checks processes, compares or hands back entries,
// then repeats per victim. After reset a clearing pass zeroes
// the free-count and matrix memories; req_ready stays low meanwhile. A stalled rsp
// holds the sequencer in its emit state; req_ready is high only when idle.
`default_nettype none
module resource_deadlock_manager_unit #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 16,
    parameter int COUNT_BITS    = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire rdm_pkg::req_word_t req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rdm_pkg::rsp_word_t     rsp_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [4:0]        cfg_data
);
    import rdm_pkg::*;

    localparam int C   = COUNT_BITS;
    localparam int PW  = $clog2(MAX_PROCESSES);
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int MAW = PW + RW;
    localparam int WB  = C + PW + 1;
    localparam int GW  = $clog2(MAX_PROCESSES * MAX_RESOURCES + 1);
    localparam int XPW = (PW + 1 > 5) ? PW + 1 : 5;
    localparam int XRW = (RW + 1 > 5) ? RW + 1 : 5;
    localparam int YPW = (PW > 4) ? PW : 4;
    localparam int YRW = (RW > 4) ? RW : 4;
    localparam int AW  = (C > 6) ? C : 6;
    localparam int GXW = (GW > 9) ? GW : 9;
    localparam logic [PW-1:0] PMAX = PW'(MAX_PROCESSES - 1);
    localparam logic [RW-1:0] RMAX = RW'(MAX_RESOURCES - 1);
    localparam logic [C-1:0]  CMAX = {C{1'b1}};

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_RQ_RD, S_RQ_WR, S_RL_RD, S_RL_WR, S_RS_RD, S_RS_EV,
        S_DW_RD, S_DW_WR, S_DF_CHK, S_DF_RD, S_DF_EV, S_DA_RD, S_DA_WR,
        S_DD, S_DV, S_DK_RD, S_DK_WR, S_FIN_RD, S_FIN_EM
    } state_t;

    state_t                   state_reg;
    logic [4:0]               procs_reg, rsrcs_reg;
    logic [PW-1:0]            p_reg, i_reg, pout_reg;
    logic [RW-1:0]            r_reg, j_reg;
    logic [C-1:0]             amt_reg;
    logic [GW-1:0]            gc_reg;
    logic [2:0]               st_reg;
    logic                     last_reg, killed_reg;
    logic [MAX_PROCESSES-1:0] wait_reg, done_reg;
    logic [MAW-1:0]           clr_reg;
    logic                     out_valid_reg;
    rsp_word_t                out_reg;

    // memories
    logic [C-1:0]   avail_mem [2**RW];
    logic [2*C-1:0] mat_mem   [2**MAW];
    logic [WB-1:0]  work_mem  [2**RW];
    logic [C-1:0]   a_q, a_wdata;
    logic [2*C-1:0] m_q, m_wdata;
    logic [WB-1:0]  w_q, w_wdata;
    logic [RW-1:0]  a_addr;
    logic [MAW-1:0] m_addr;
    logic           a_re, a_we, m_re, m_we, w_re, w_we;

    // unit hookup
    logic          alu_sub, alu_ge;
    logic [WB-1:0] alu_x, alu_y, alu_res;
    logic [C-1:0]  alu_u, alu_v, alu_sat;

    logic [C-1:0]  alloc, pend;
    logic [PW-1:0] npm, p_sat;
    logic [RW-1:0] nrm, r_sat;
    logic [C-1:0]  amt_sat;
    logic          i_last, j_last, slot_free;
    rsp_word_t     out_word;

    assign alloc     = m_q[2*C-1:C];
    assign pend      = m_q[C-1:0];
    assign i_last    = (i_reg == npm);
    assign j_last    = (j_reg == nrm);
    assign slot_free = ~out_valid_reg | rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // active counts and index saturation
    always_comb
    begin
        logic [XPW-1:0] npx, npx_m1;
        logic [XRW-1:0] nrx, nrx_m1;
        logic [YPW-1:0] pix;
        logic [YRW-1:0] rix;
        logic [AW-1:0]  amx;
        npx    = XPW'(procs_reg);
        npx_m1 = npx - 1'b1;
        nrx    = XRW'(rsrcs_reg);
        nrx_m1 = nrx - 1'b1;
        if (procs_reg == 5'd0)
            npm = '0;
        else if (npx > XPW'(MAX_PROCESSES))
            npm = PMAX;
        else
            npm = npx_m1[PW-1:0];
        if (rsrcs_reg == 5'd0)
            nrm = '0;
        else if (nrx > XRW'(MAX_RESOURCES))
            nrm = RMAX;
        else
            nrm = nrx_m1[RW-1:0];
        pix   = YPW'(req_data.process_index);
        p_sat = (pix > YPW'(npm)) ? npm : pix[PW-1:0];
        rix   = YRW'(req_data.resource_index);
        r_sat = (rix > YRW'(nrm)) ? nrm : rix[RW-1:0];
        amx   = AW'(req_data.amount);
        amt_sat = (amx > AW'(CMAX)) ? CMAX : amx[C-1:0];
    end

    rdm_alu #(.CB(C), .WB(WB)) u_alu (
        .sub (alu_sub),
        .x   (alu_x),
        .y   (alu_y),
        .u   (alu_u),
        .v   (alu_v),
        .res (alu_res),
        .ge  (alu_ge),
        .sat (alu_sat)
    );

    // unit operands and memory controls per state
    always_comb
    begin
        alu_sub = 1'b1;
        alu_x   = '0;
        alu_y   = '0;
        alu_u   = '0;
        alu_v   = '0;
        a_re = 1'b0; a_we = 1'b0; a_wdata = '0;
        m_re = 1'b0; m_we = 1'b0; m_wdata = '0;
        w_re = 1'b0; w_we = 1'b0; w_wdata = '0;
        unique case (state_reg)
            S_CLR, S_IDLE:                  a_addr = (state_reg == S_CLR) ? clr_reg[RW-1:0]
                                                                          : r_sat;
            S_RQ_RD, S_RQ_WR, S_RL_RD, S_RL_WR, S_FIN_RD, S_FIN_EM: a_addr = r_reg;
            default:                        a_addr = j_reg;
        endcase
        unique case (state_reg)
            S_CLR:                              m_addr = clr_reg;
            S_RQ_RD, S_RQ_WR, S_RL_RD, S_RL_WR: m_addr = {p_reg, r_reg};
            default:                            m_addr = {i_reg, j_reg};
        endcase
        unique case (state_reg)
            S_CLR:
            begin
                a_we = 1'b1;
                m_we = 1'b1;
            end
            S_IDLE:
            begin
                a_we    = req_valid && (req_data.opcode == OP_LOAD);
                a_wdata = amt_sat;
            end
            S_RQ_RD, S_RL_RD, S_RS_RD, S_DK_RD:
            begin
                a_re = 1'b1;
                m_re = 1'b1;
            end
            S_RQ_WR:
            begin
                alu_x = {{(WB-C){1'b0}}, a_q};
                alu_y = {{(WB-C){1'b0}}, amt_reg};
                alu_u = alloc;
                alu_v = amt_reg;
                m_we  = 1'b1;
                if (alu_ge)
                begin
                    a_we    = 1'b1;
                    a_wdata = alu_res[C-1:0];
                    m_wdata = {alu_sat, {C{1'b0}}};
                end
                else
                    m_wdata = {alloc, amt_reg};
            end
            S_RL_WR:
            begin
                alu_x   = {{(WB-C){1'b0}}, alloc};
                alu_y   = {{(WB-C){1'b0}}, amt_reg};
                alu_u   = a_q;
                alu_v   = alu_ge ? amt_reg : alloc;
                a_we    = 1'b1;
                a_wdata = alu_sat;
                m_we    = 1'b1;
                m_wdata = {(alu_ge ? alu_res[C-1:0] : {C{1'b0}}), pend};
            end
            S_RS_EV:
            begin
                alu_x = {{(WB-C){1'b0}}, a_q};
                alu_y = {{(WB-C){1'b0}}, pend};
                alu_u = alloc;
                alu_v = pend;
                if ((pend != '0) && alu_ge)
                begin
                    a_we    = 1'b1;
                    a_wdata = alu_res[C-1:0];
                    m_we    = 1'b1;
                    m_wdata = {alu_sat, {C{1'b0}}};
                end
            end
            S_DW_RD, S_FIN_RD:
                a_re = 1'b1;
            S_DW_WR:
            begin
                w_we    = 1'b1;
                w_wdata = {{(WB-C){1'b0}}, a_q};
            end
            S_DF_RD, S_DA_RD:
            begin
                m_re = 1'b1;
                w_re = 1'b1;
            end
            S_DF_EV:
            begin
                alu_x = w_q;
                alu_y = {{(WB-C){1'b0}}, pend};
            end
            S_DA_WR:
            begin
                alu_sub = 1'b0;
                alu_x   = w_q;
                alu_y   = {{(WB-C){1'b0}}, alloc};
                w_we    = 1'b1;
                w_wdata = alu_res;
            end
            S_DK_WR:
            begin
                alu_u   = a_q;
                alu_v   = alloc;
                a_we    = 1'b1;
                a_wdata = alu_sat;
                m_we    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            avail_mem[a_addr] <= a_wdata;
        if (a_re)
            a_q <= avail_mem[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
            mat_mem[m_addr] <= m_wdata;
        if (m_re)
            m_q <= mat_mem[m_addr];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            work_mem[j_reg] <= w_wdata;
        if (w_re)
            w_q <= work_mem[j_reg];
    end

    // result word
    always_comb
    begin
        logic [YPW-1:0] pox;
        logic [AW-1:0]  avx;
        logic [GXW-1:0] gcx;
        pox = YPW'(pout_reg);
        avx = AW'(a_q);
        gcx = GXW'(gc_reg);
        out_word.status        = st_reg;
        out_word.process_out   = pox[3:0];
        out_word.available_out = avx[5:0];
        out_word.grant_count   = gcx[8:0];
        out_word.last          = last_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            procs_reg <= 5'd16;
            rsrcs_reg <= 5'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PROCS: procs_reg <= cfg_data;
                CFG_RSRCS: rsrcs_reg <= cfg_data;
                default:   procs_reg <= procs_reg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            p_reg         <= '0;
            r_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            pout_reg      <= '0;
            amt_reg       <= '0;
            gc_reg        <= '0;
            st_reg        <= ST_NO_DL;
            last_reg      <= 1'b1;
            killed_reg    <= 1'b0;
            wait_reg      <= '0;
            done_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // result register: set on emit, dropped once taken
            if ((state_reg == S_FIN_EM) && slot_free)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        p_reg      <= p_sat;
                        r_reg      <= r_sat;
                        amt_reg    <= amt_sat;
                        gc_reg     <= '0;
                        pout_reg   <= '0;
                        last_reg   <= 1'b1;
                        killed_reg <= 1'b0;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        unique case (req_data.opcode)
                            OP_LOAD:
                            begin
                                st_reg    <= ST_LOADED;
                                state_reg <= S_FIN_RD;
                            end
                            OP_REQUEST: state_reg <= S_RQ_RD;
                            OP_RELEASE: state_reg <= S_RL_RD;
                            OP_RESCAN:  state_reg <= S_RS_RD;
                            OP_DETECT:  state_reg <= S_DW_RD;
                            default:
                            begin
                                st_reg    <= ST_NO_DL;
                                state_reg <= S_FIN_RD;
                            end
                        endcase
                    end
                end
                S_RQ_RD: state_reg <= S_RQ_WR;
                S_RQ_WR:
                begin
                    pout_reg <= p_reg;
                    if (alu_ge)
                        st_reg <= ST_GRANTED;
                    else
                    begin
                        st_reg          <= ST_WAITING;
                        wait_reg[p_reg] <= 1'b1;
                    end
                    state_reg <= S_FIN_RD;
                end
                S_RL_RD: state_reg <= S_RL_WR;
                S_RL_WR:
                begin
                    pout_reg  <= p_reg;
                    st_reg    <= ST_RELEASED;
                    wait_reg  <= '0;
                    state_reg <= S_FIN_RD;
                end
                // rescan: read and evaluate each matrix entry in turn
                S_RS_RD: state_reg <= S_RS_EV;
                S_RS_EV:
                begin
                    if (pend != '0)
                    begin
                        if (alu_ge)
                            gc_reg <= gc_reg + 1'b1;
                        else
                            wait_reg[i_reg] <= 1'b1;
                    end
                    state_reg <= S_RS_RD;
                    if (j_last)
                    begin
                        j_reg <= '0;
                        if (i_last)
                        begin
                            st_reg    <= ST_GRANTED;
                            state_reg <= S_FIN_RD;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                // detect: copy free counts into work
                S_DW_RD: state_reg <= S_DW_WR;
                S_DW_WR:
                begin
                    if (j_last)
                    begin
                        j_reg     <= '0;
                        i_reg     <= '0;
                        done_reg  <= '0;
                        state_reg <= S_DF_CHK;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_DW_RD;
                    end
                end
                // find an unfinished process whose requests fit in work
                S_DF_CHK:
                begin
                    if (done_reg[i_reg])
                    begin
                        if (i_last)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_DD;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        state_reg <= S_DF_RD;
                    end
                end
                S_DF_RD: state_reg <= S_DF_EV;
                S_DF_EV:
                begin
                    if (!alu_ge)
                    begin
                        if (i_last)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_DD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_DF_CHK;
                        end
                    end
                    else if (j_last)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_DA_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_DF_RD;
                    end
                end
                // fitting process hands its holdings back to work
                S_DA_RD: state_reg <= S_DA_WR;
                S_DA_WR:
                begin
                    if (j_last)
                    begin
                        done_reg[i_reg] <= 1'b1;
                        i_reg           <= '0;
                        j_reg           <= '0;
                        state_reg       <= S_DF_CHK;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_DA_RD;
                    end
                end
                // any unfinished process means deadlock
                S_DD:
                begin
                    if (!done_reg[i_reg])
                    begin
                        i_reg     <= '0;
                        state_reg <= S_DV;
                    end
                    else if (i_last)
                    begin
                        st_reg    <= ST_NO_DL;
                        pout_reg  <= '0;
                        last_reg  <= 1'b1;
                        if (killed_reg)
                            wait_reg <= '0;
                        state_reg <= S_FIN_RD;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                // lowest waiting process becomes the victim
                S_DV:
                begin
                    if (wait_reg[i_reg])
                    begin
                        j_reg     <= '0;
                        state_reg <= S_DK_RD;
                    end
                    else if (i_last)
                    begin
                        st_reg    <= ST_NO_WAIT;
                        pout_reg  <= '0;
                        last_reg  <= 1'b1;
                        if (killed_reg)
                            wait_reg <= '0;
                        state_reg <= S_FIN_RD;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                S_DK_RD: state_reg <= S_DK_WR;
                S_DK_WR:
                begin
                    if (j_last)
                    begin
                        wait_reg[i_reg] <= 1'b0;
                        killed_reg      <= 1'b1;
                        st_reg          <= ST_VICTIM;
                        pout_reg        <= i_reg;
                        last_reg        <= 1'b0;
                        state_reg       <= S_FIN_RD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_DK_RD;
                    end
                end
                S_FIN_RD: state_reg <= S_FIN_EM;
                S_FIN_EM:
                begin
                    if (slot_free)
                    begin
                        out_reg       <= out_word;
                        j_reg         <= '0;
                        state_reg     <= last_reg ? S_IDLE : S_DW_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // block is busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("accepted a word on back-to-back cycles");

    // only victim results leave more to come
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.last |-> rsp_data.status == ST_VICTIM)
        else $error("non-final result with wrong status");

    // release clears every waiting flag
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RL_WR |=> wait_reg == '0)
        else $error("waiting flags survive a release");
`endif

endmodule
`default_nettype wire
